### rtl/timed_relay_dosing_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed relay dosing sequencer.
// Both macros compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIMED_RELAY_DOSING_SEQUENCER_DEFINES_SVH
`define TIMED_RELAY_DOSING_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TRDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TRDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define TRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/trds_pkg.sv
// ----------------------------------------------------------------------------
// trds_pkg
// Shared constants, payload structs and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package trds_pkg;

  localparam int MAX_ENTRIES      = 6;
  localparam int RELAY_COUNT      = 8;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int MIN_ON_MS        = 100;

  localparam int INTERVAL_W = 12;
  localparam int DUR_W      = 20;
  localparam int RELAY_W    = 3;
  localparam int OPCODE_W   = 3;
  localparam int PHASE_W    = 2;
  localparam int POS_W      = 3;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Longest wait is the largest interval times the tick rate.
  localparam longint MAX_WAIT  = 64'(4095) * 64'(TICKS_PER_SECOND);
  localparam int     WAIT_W    = $clog2(MAX_WAIT + 1);
  localparam int     ELAPSED_W = (WAIT_W > DUR_W) ? WAIT_W : DUR_W;

  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_START  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CANCEL = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_ESTOP  = 3'd4;

  localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_DOSING  = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_WAITING = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [RELAY_W-1:0]  entry_relay;
    logic [DUR_W-1:0]    entry_duration_ms;
  } in_item_t;

  typedef struct packed {
    logic                   accepted;
    logic [PHASE_W-1:0]     phase;
    logic [POS_W-1:0]       entry_position;
    logic                   sequence_done;
    logic [RELAY_COUNT-1:0] relay_mask;
    logic [7:0]             expander_a_pins;
    logic [7:0]             expander_b_pins;
  } out_item_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay;
    logic [DUR_W-1:0]   dur;
  } entry_t;

  // Commands from the controller, valid in the cycle of a transfer.
  typedef struct packed {
    logic               tab_write;
    logic               elapsed_inc;
    logic               elapsed_clear;
    logic               entry_inc;
    logic               seq_clear;
    logic               relay_on;
    logic               relay_off;
    logic               relay_all_off;
    logic               accepted;
    logic               done;
    logic [PHASE_W-1:0] phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dose_due;
    logic wait_due;
    logic last_entry;
    logic list_full;
    logic list_empty;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/trds_controller.sv
// ----------------------------------------------------------------------------
// trds_controller
// Phase state machine: decodes each command against the current phase and
// the datapath status, and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_relay_dosing_sequencer_defines.svh"

module trds_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           fire,
  input  wire logic [trds_pkg::OPCODE_W-1:0]  opcode,
  input  wire trds_pkg::dp_status_t           status,
  output trds_pkg::ctrl_cmd_t                 cmd
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_DOSING  = 3'b010,
    ST_WAITING = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (opcode)
      trds_pkg::OP_TICK: begin
        if (state_r != ST_IDLE) begin
          cmd.accepted    = 1'b1;
          cmd.elapsed_inc = 1'b1;
          if (state_r == ST_DOSING) begin
            if (status.dose_due) begin
              cmd.relay_off = 1'b1;
              if (status.last_entry) begin
                cmd.seq_clear = 1'b1;
                cmd.done      = 1'b1;
                state_nxt     = ST_IDLE;
              end else begin
                cmd.entry_inc     = 1'b1;
                cmd.elapsed_clear = 1'b1;
                state_nxt         = ST_WAITING;
              end
            end
          end else if (status.wait_due) begin
            cmd.relay_on      = 1'b1;
            cmd.elapsed_clear = 1'b1;
            state_nxt         = ST_DOSING;
          end
        end
      end
      trds_pkg::OP_APPEND: begin
        if (state_r == ST_IDLE && !status.list_full) begin
          cmd.tab_write = 1'b1;
          cmd.accepted  = 1'b1;
        end
      end
      trds_pkg::OP_START: begin
        // The position is always zero while idle, so the first entry is read.
        if (state_r == ST_IDLE && !status.list_empty) begin
          cmd.relay_on      = 1'b1;
          cmd.elapsed_clear = 1'b1;
          cmd.accepted      = 1'b1;
          state_nxt         = ST_DOSING;
        end
      end
      trds_pkg::OP_CANCEL: begin
        if (state_r != ST_IDLE) begin
          cmd.relay_off = (state_r == ST_DOSING);
          cmd.seq_clear = 1'b1;
          cmd.accepted  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      trds_pkg::OP_ESTOP: begin
        // Relays drop but the phase and timing carry on.
        cmd.relay_all_off = 1'b1;
        cmd.accepted      = 1'b1;
      end
      default: begin
        cmd.accepted = 1'b0;
      end
    endcase

    case (state_nxt)
      ST_DOSING:  cmd.phase = trds_pkg::PHASE_DOSING;
      ST_WAITING: cmd.phase = trds_pkg::PHASE_WAITING;
      default:    cmd.phase = trds_pkg::PHASE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  `TRDS_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, fire && cmd.done, state_r == ST_IDLE,
    "sequence done without returning to idle")
  `TRDS_ASSERT_IMPLY(a_relay_cmd_excl, clk, rst_n, cmd.relay_on, !cmd.relay_off,
    "relay switched on and off by one command")
  `TRDS_ASSERT_IMPLY(a_append_idle_only, clk, rst_n, fire && cmd.tab_write,
    state_r == ST_IDLE, "entry written outside idle")

endmodule

`default_nettype wire

### rtl/trds_datapath.sv
// ----------------------------------------------------------------------------
// trds_datapath
// Entry list, position and time counters, relay bits, wait threshold and the
// result register with its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_relay_dosing_sequencer_defines.svh"

module trds_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [trds_pkg::INTERVAL_W-1:0]  cfg_wdata,
  input  wire logic                             fire,
  input  wire trds_pkg::in_item_t               in_item,
  input  wire trds_pkg::ctrl_cmd_t              cmd,
  output trds_pkg::dp_status_t                  status,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output trds_pkg::out_item_t                   out_item
);

  localparam int IDX_W     = trds_pkg::IDX_W;
  localparam int CNT_W     = trds_pkg::CNT_W;
  localparam int ELAPSED_W = trds_pkg::ELAPSED_W;
  localparam int WAIT_W    = trds_pkg::WAIT_W;
  localparam int DUR_W     = trds_pkg::DUR_W;
  localparam int RC        = trds_pkg::RELAY_COUNT;

  trds_pkg::entry_t           tab_r [trds_pkg::MAX_ENTRIES];
  logic [WAIT_W-1:0]          wait_ticks_r;
  logic [CNT_W-1:0]           total_r, total_nxt;
  logic [CNT_W-1:0]           cur_r, cur_nxt;
  logic [ELAPSED_W-1:0]       elapsed_r, elapsed_nxt;
  logic [RC-1:0]              relay_r, relay_nxt;
  logic                       out_valid_r;
  trds_pkg::out_item_t        out_item_r, out_item_nxt;

  logic [IDX_W-1:0]           k;
  logic [ELAPSED_W-1:0]       elapsed_inc;
  logic [CNT_W:0]             cur_plus;
  logic [DUR_W-1:0]           dur_clamped;
  trds_pkg::entry_t           cur_entry;

  always_comb begin
    k = (cur_r < CNT_W'(trds_pkg::MAX_ENTRIES)) ? cur_r[IDX_W-1:0] : '0;
    cur_entry   = tab_r[k];
    // The counter restarts at each timeout, so it never outgrows its width.
    elapsed_inc = elapsed_r + ELAPSED_W'(1);
    cur_plus    = {1'b0, cur_r} + (CNT_W + 1)'(1);

    status.dose_due   = elapsed_inc >= ELAPSED_W'(cur_entry.dur);
    status.wait_due   = elapsed_inc >= ELAPSED_W'(wait_ticks_r);
    status.last_entry = cur_plus >= {1'b0, total_r};
    status.list_full  = total_r >= CNT_W'(trds_pkg::MAX_ENTRIES);
    status.list_empty = total_r == '0;

    dur_clamped = (in_item.entry_duration_ms < DUR_W'(trds_pkg::MIN_ON_MS)) ?
                  DUR_W'(trds_pkg::MIN_ON_MS) : in_item.entry_duration_ms;
  end

  always_comb begin
    total_nxt   = total_r;
    cur_nxt     = cur_r;
    elapsed_nxt = elapsed_r;
    relay_nxt   = relay_r;

    if (cmd.tab_write) begin
      total_nxt = total_r + CNT_W'(1);
    end
    if (cmd.elapsed_inc) begin
      elapsed_nxt = elapsed_inc;
    end
    if (cmd.elapsed_clear) begin
      elapsed_nxt = '0;
    end
    if (cmd.entry_inc) begin
      cur_nxt = cur_plus[CNT_W-1:0];
    end
    if (cmd.seq_clear) begin
      total_nxt   = '0;
      cur_nxt     = '0;
      elapsed_nxt = '0;
    end
    if (cmd.relay_off) begin
      relay_nxt[cur_entry.relay] = 1'b0;
    end
    if (cmd.relay_on) begin
      // On a wait timeout the relay comes from the entry the position now names.
      relay_nxt[cur_entry.relay] = 1'b1;
    end
    if (cmd.relay_all_off) begin
      relay_nxt = '0;
    end

    out_item_nxt.accepted        = cmd.accepted;
    out_item_nxt.phase           = cmd.phase;
    out_item_nxt.entry_position  = trds_pkg::POS_W'(cur_nxt);
    out_item_nxt.sequence_done   = cmd.done;
    out_item_nxt.relay_mask      = relay_nxt;
    out_item_nxt.expander_a_pins = {1'b1, ~relay_nxt[6:0]};
    out_item_nxt.expander_b_pins = {6'h3F, ~relay_nxt[7], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= '0;
      total_r      <= '0;
      cur_r        <= '0;
      elapsed_r    <= '0;
      relay_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        wait_ticks_r <= WAIT_W'(cfg_wdata) * WAIT_W'(trds_pkg::TICKS_PER_SECOND);
      end
      if (fire) begin
        total_r   <= total_nxt;
        cur_r     <= cur_nxt;
        elapsed_r <= elapsed_nxt;
        relay_r   <= relay_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
    if (fire && cmd.tab_write) begin
      tab_r[total_r[IDX_W-1:0]] <= '{relay: in_item.entry_relay, dur: dur_clamped};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TRDS_ASSERT_IMPLY(a_total_bound, clk, rst_n, 1'b1,
    total_r <= CNT_W'(trds_pkg::MAX_ENTRIES), "entry count above list size")
  `TRDS_ASSERT_IMPLY(a_cur_bound, clk, rst_n, 1'b1, cur_r <= total_r,
    "position beyond entry count")

endmodule

`default_nettype wire

### rtl/timed_relay_dosing_sequencer.sv
// ----------------------------------------------------------------------------
// timed_relay_dosing_sequencer: eight-relay pump dosing sequencer
// The result of a transfer is registered and valid the cycle after it.
// Throughput 1 item per cycle while out_ready is high, set by the result register.
// Reset clears phase, list, counters, relays and the interval; entries are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_relay_dosing_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [trds_pkg::INTERVAL_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire trds_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output trds_pkg::out_item_t                   out_data
);

  logic                 fire;
  trds_pkg::ctrl_cmd_t  cmd;
  trds_pkg::dp_status_t status;

  // A new transfer can be taken whenever the result register is empty or empties this cycle.
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  trds_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .opcode (in_data.opcode),
    .status (status),
    .cmd    (cmd)
  );

  trds_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_item   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire
